### rtl/fbda_pkg.sv
// Package for the five-button debounce and auto-repeat block.
// Holds the sizes, codes and shared types; depends on nothing else.
package fbda_pkg;

  // Block sizes.
  localparam int NUM_BUTTONS    = 5;
  localparam int TIME_BITS      = 32;
  localparam int REPEAT_BUTTONS = 2;
  localparam int CFG_W          = 16;
  localparam int CODE_W         = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int BTN_IDX_W      = $clog2(NUM_BUTTONS);

  // Command codes carried by the input item.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  // Configuration reset values in milliseconds.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd500;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd200;

  // Timing configuration as seen by the state logic.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_delay_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic              event_ready;
    logic [CODE_W-1:0] action_code;
  } result_t;

endpackage

### rtl/fbda_core.sv
// Button state registers with the debounce, press detection and repeat logic.
// Depends on fbda_pkg.
module fbda_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  logic                            cmd,
  input  logic [fbda_pkg::NUM_BUTTONS-1:0] pin_levels,
  input  logic [fbda_pkg::TIME_BITS-1:0]  now_ms,
  input  fbda_pkg::cfg_t                  cfg,
  output fbda_pkg::result_t               result
);
  import fbda_pkg::*;

  logic                       started_r, started_nxt;
  logic [NUM_BUTTONS-1:0]     raw_r, raw_nxt;
  logic [NUM_BUTTONS-1:0]     stable_r, stable_nxt;
  logic [NUM_BUTTONS-1:0]     armed_r, armed_nxt;
  logic [TIME_BITS-1:0]       lct_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]       lct_nxt [NUM_BUTTONS];
  logic [TIME_BITS-1:0]       nrt_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]       nrt_nxt [NUM_BUTTONS];

  // Control state is cleared by reset; the time stamps are rewritten on start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      raw_r     <= '0;
      stable_r  <= '0;
      armed_r   <= '0;
    end else begin
      started_r <= started_nxt;
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
      armed_r   <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lct_r <= lct_nxt;
    nrt_r <= nrt_nxt;
  end

  // Next state and the result for the item in the input register.
  always_comb begin
    logic                   pressed;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   diff;
    logic [NUM_BUTTONS-1:0] new_press;
    logic [REPEAT_BUTTONS-1:0] due;
    logic [BTN_IDX_W-1:0]   sel;

    started_nxt = started_r;
    raw_nxt     = raw_r;
    stable_nxt  = stable_r;
    armed_nxt   = armed_r;
    lct_nxt     = lct_r;
    nrt_nxt     = nrt_r;
    result      = '0;
    pressed     = 1'b0;
    elapsed     = '0;
    diff        = '0;
    new_press   = '0;
    due         = '0;
    sel         = '0;

    if (step_en) begin
      if (cmd == CMD_START) begin
        // A start seeds every button from the pins and disarms all repeats.
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          raw_nxt[i]    = ~pin_levels[i];
          stable_nxt[i] = ~pin_levels[i];
          armed_nxt[i]  = 1'b0;
          lct_nxt[i]    = now_ms;
          nrt_nxt[i]    = '0;
        end
        started_nxt = 1'b1;
      end else if (started_r) begin
        // Per-button change tracking and debounce, all buttons in parallel.
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          pressed = ~pin_levels[i];
          if (pressed != raw_r[i]) begin
            raw_nxt[i] = pressed;
            lct_nxt[i] = now_ms;
            if (!pressed) begin
              armed_nxt[i] = 1'b0;
              nrt_nxt[i]   = '0;
            end
          end
          elapsed = now_ms - lct_nxt[i];
          if ((stable_r[i] != raw_nxt[i]) && (elapsed >= TIME_BITS'(cfg.debounce_ms))) begin
            stable_nxt[i] = raw_nxt[i];
            if (raw_nxt[i]) begin
              nrt_nxt[i]   = now_ms + TIME_BITS'(cfg.repeat_delay_ms);
              armed_nxt[i] = 1'b1;
              new_press[i] = 1'b1;
            end else begin
              armed_nxt[i] = 1'b0;
              nrt_nxt[i]   = '0;
            end
          end
        end

        if (|new_press) begin
          // The lowest-index new press wins.
          for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (new_press[i]) begin
              sel = BTN_IDX_W'(i);
            end
          end
          result.event_ready = 1'b1;
          result.action_code = CODE_W'(sel);
        end else begin
          // Repeat check on the held buttons that auto-repeat.
          for (int i = 0; i < REPEAT_BUTTONS; i++) begin
            diff   = now_ms - nrt_nxt[i];
            due[i] = raw_nxt[i] & stable_nxt[i] & armed_nxt[i] & ~diff[TIME_BITS-1];
          end
          for (int i = REPEAT_BUTTONS - 1; i >= 0; i--) begin
            if (due[i]) begin
              sel = BTN_IDX_W'(i);
            end
          end
          if (|due) begin
            nrt_nxt[sel]       = now_ms + TIME_BITS'(cfg.repeat_interval_ms);
            result.event_ready = 1'b1;
            result.action_code = CODE_W'(sel);
          end
        end
      end
    end
  end

endmodule

### rtl/five_button_debounce_autorepeat.sv
// Top level of the five-button debounce and auto-repeat block.
// Holds the input and output registers and the configuration registers;
// depends on fbda_pkg and fbda_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, pin_levels (active low)
//   and now_ms. A start command seeds the button state; polls then debounce
//   the pins and report presses and Up/Down auto-repeats.
//   Output channel (out_valid / out_stall) returns one result per item:
//   out_event_ready and out_action_code (0 when no event).
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   debounce_ms, repeat_delay_ms and repeat_interval_ms; it is always ready
//   and should be written only while the block is idle.
// Path: each item is held in the input register, passes through the state
//   update logic and is held in the result register until it transfers.
// Throughput: one item per cycle unless out_stall holds a result, set by the
//   single pass through the update logic between input and result registers.
// Reset: clears both pipeline stages, the button state and loads the default
//   timings (30, 500, 200 ms). Polls before the first start give no event.
// Stall: while out_stall holds a waiting result, the pipeline freezes; an
//   item still enters the empty input register, then in_stall rises.
module five_button_debounce_autorepeat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [fbda_pkg::NUM_BUTTONS-1:0]  in_pin_levels,
  input  logic [fbda_pkg::TIME_BITS-1:0]    in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_event_ready,
  output logic [fbda_pkg::CODE_W-1:0]       out_action_code,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbda_pkg::CFG_W-1:0]        cfg_data
);
  import fbda_pkg::*;

  logic                   s1_valid_r;
  logic                   s1_cmd_r;
  logic [NUM_BUTTONS-1:0] s1_pins_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic                   out_valid_r;
  result_t                out_res_r;
  cfg_t                   cfg_r;
  result_t                step_res;
  logic                   advance;
  logic                   in_take;

  // Stage one moves on when the output register is empty or being drained.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_cmd;
      s1_pins_r <= in_pin_levels;
      s1_now_r  <= in_now_ms;
    end
  end

  // Button state and event logic.
  fbda_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .cmd        (s1_cmd_r),
    .pin_levels (s1_pins_r),
    .now_ms     (s1_now_r),
    .cfg        (cfg_r),
    .result     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_ready = out_res_r.event_ready;
  assign out_action_code = out_res_r.action_code;

  // Configuration registers; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms        <= DEBOUNCE_RST;
      cfg_r.repeat_delay_ms    <= DELAY_RST;
      cfg_r.repeat_interval_ms <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ms        <= cfg_data;
        CFG_DELAY:    cfg_r.repeat_delay_ms    <= cfg_data;
        CFG_INTERVAL: cfg_r.repeat_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### test/nav_event_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the five-button debounce and auto-repeat block.
// Watches the item, result and timing-register channels and predicts each result.
// Depends on fbda_pkg only.
module nav_event_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [fbda_pkg::NUM_BUTTONS-1:0] in_pin_levels,
  input  logic [fbda_pkg::TIME_BITS-1:0]   in_now_ms,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_event_ready,
  input  logic [fbda_pkg::CODE_W-1:0]      out_action_code,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fbda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbda_pkg::CFG_W-1:0]       cfg_data,
  output int                               fail_count,
  output int                               pending_count,
  output int                               event_count
);
  import fbda_pkg::*;

  // Timing settings as the block should currently hold them.
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] delay_ms;
  logic [CFG_W-1:0] interval_ms;

  // Shadow copy of the button state.
  logic                   seeded;
  logic [NUM_BUTTONS-1:0] raw_dn;
  logic [NUM_BUTTONS-1:0] stable_dn;
  logic [NUM_BUTTONS-1:0] repeat_on;
  logic [TIME_BITS-1:0]   change_at [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   repeat_at [NUM_BUTTONS];

  // Results still owed by the block, oldest first.
  result_t nav_expected [$];

  // Advances the shadow state by one item and returns the navigation event it gives.
  function automatic result_t predict_nav_event(input logic cmd,
                                                input logic [NUM_BUTTONS-1:0] pins,
                                                input logic [TIME_BITS-1:0] now);
    result_t              res;
    logic                 pressed;
    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] lag;
    int                   b;
    res = '0;

    // A start seeds every button from the pins, with no repeat pending.
    if (cmd == CMD_START) begin
      for (b = 0; b < NUM_BUTTONS; b++) begin
        raw_dn[b]    = ~pins[b];
        stable_dn[b] = ~pins[b];
        change_at[b] = now;
        repeat_at[b] = '0;
        repeat_on[b] = 1'b0;
      end
      seeded = 1'b1;
      return res;
    end
    if (!seeded) begin
      return res;
    end

    // Track raw changes, then promote levels that have held long enough.
    for (b = 0; b < NUM_BUTTONS; b++) begin
      pressed = ~pins[b];
      if (pressed != raw_dn[b]) begin
        raw_dn[b]    = pressed;
        change_at[b] = now;
        if (!pressed) begin
          repeat_on[b] = 1'b0;
          repeat_at[b] = '0;
        end
      end
      held = now - change_at[b];
      if (stable_dn[b] != raw_dn[b] && held >= TIME_BITS'(debounce_ms)) begin
        stable_dn[b] = raw_dn[b];
        if (stable_dn[b]) begin
          repeat_at[b] = now + TIME_BITS'(delay_ms);
          repeat_on[b] = 1'b1;
          if (!res.event_ready) begin
            res.event_ready = 1'b1;
            res.action_code = CODE_W'(b);
          end
        end else begin
          repeat_on[b] = 1'b0;
          repeat_at[b] = '0;
        end
      end
    end

    // With no fresh press, the first held Up or Down whose repeat is due fires.
    for (b = 0; b < REPEAT_BUTTONS && !res.event_ready; b++) begin
      lag = now - repeat_at[b];
      if (raw_dn[b] && stable_dn[b] && repeat_on[b] && !lag[TIME_BITS-1]) begin
        repeat_at[b]    = now + TIME_BITS'(interval_ms);
        res.event_ready = 1'b1;
        res.action_code = CODE_W'(b);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      b;
    if (!rst_n) begin
      debounce_ms = DEBOUNCE_RST;
      delay_ms    = DELAY_RST;
      interval_ms = INTERVAL_RST;
      seeded      = 1'b0;
      raw_dn      = '0;
      stable_dn   = '0;
      repeat_on   = '0;
      for (b = 0; b < NUM_BUTTONS; b++) begin
        change_at[b] = '0;
        repeat_at[b] = '0;
      end
      nav_expected.delete();
      fail_count  = 0;
      event_count = 0;
    end else begin
      // Timing register writes take effect for the items that follow.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_ms = cfg_data;
          CFG_DELAY:    delay_ms    = cfg_data;
          CFG_INTERVAL: interval_ms = cfg_data;
          default: ;
        endcase
      end

      // Compare each result transfer against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (nav_expected.size() == 0) begin
          $error("Unexpected result: event_ready %0d, action_code %0d",
                 out_event_ready, out_action_code);
          fail_count++;
        end else begin
          want = nav_expected.pop_front();
          if (out_event_ready !== want.event_ready) begin
            $error("event_ready mismatch: expected %0d, actual %0d",
                   want.event_ready, out_event_ready);
            fail_count++;
          end
          if (out_action_code !== want.action_code) begin
            $error("action_code mismatch: expected %0d, actual %0d",
                   want.action_code, out_action_code);
            fail_count++;
          end
        end
        if (out_event_ready === 1'b1) begin
          event_count++;
        end
      end

      // Each item transfer owes exactly one result.
      if (in_valid && !in_stall) begin
        nav_expected.push_back(predict_nav_event(in_cmd, in_pin_levels, in_now_ms));
      end
    end
    pending_count <= nav_expected.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for the five-button debounce and auto-repeat block.
// Drives button polls and timing settings; depends on fbda_pkg, the block
// and nav_event_checker, which gives the failure count used for the verdict.
module testbench;
  import fbda_pkg::*;

  // How the two channels idle during a phase.
  typedef enum {RECV_HEAVY, SEND_HEAVY, NO_IDLE} idle_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = CMD_START;
  logic [NUM_BUTTONS-1:0] in_pin_levels = '1;
  logic [TIME_BITS-1:0]   in_now_ms = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_event_ready;
  logic [CODE_W-1:0]      out_action_code;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]       cfg_data = '0;

  int fail_count;
  int pending_count;
  int event_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int settings_used = 1;

  // Simulated button pins and millisecond clock.
  logic [NUM_BUTTONS-1:0] pin_state = '1;
  logic [TIME_BITS-1:0]   clock_ms = '0;

  five_button_debounce_autorepeat u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_pin_levels   (in_pin_levels),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_ready (out_event_ready),
    .out_action_code (out_action_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  nav_event_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_pin_levels   (in_pin_levels),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_ready (out_event_ready),
    .out_action_code (out_action_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .event_count     (event_count)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side stalls at random, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      RECV_HEAVY: begin
        send_idle_pct  = 12;
        recv_stall_pct = 53;
      end
      SEND_HEAVY: begin
        send_idle_pct  = 53;
        recv_stall_pct = 12;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Offers one item and returns at the edge where its transfer happens.
  task automatic send_item(input logic cmd, input logic [NUM_BUTTONS-1:0] pins,
                           input logic [TIME_BITS-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_pin_levels <= pins;
    in_now_ms     <= now;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // One register write; cfg_valid stays high so writes can follow back to back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Loads a timing setting while idle, then runs mostly well-formed poll traffic.
  task automatic run_timing_phase(input idle_mode_t mode, input logic [CFG_W-1:0] deb,
                                  input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] ivl,
                                  input int step_max, input int n_items);
    int k;
    int roll;
    int btn;
    drain();
    set_idling(mode);
    cfg_write(CFG_DEBOUNCE, deb);
    cfg_write(CFG_DELAY, dly);
    cfg_write(CFG_INTERVAL, ivl);
    cfg_valid <= 1'b0;
    settings_used++;

    // Seed the block, sometimes just short of the time wrap.
    pin_state = NUM_BUTTONS'($urandom);
    if ($urandom_range(2) == 0) begin
      clock_ms = '1 - TIME_BITS'($urandom_range(8 * step_max));
    end else begin
      clock_ms = $urandom;
    end
    send_item(CMD_START, pin_state, clock_ms);

    for (k = 1; k < n_items; k++) begin
      // Time mostly creeps forward; now and then it stalls or jumps anywhere.
      roll = $urandom_range(99);
      if (roll >= 8 && roll < 90) begin
        clock_ms = clock_ms + TIME_BITS'($urandom_range(step_max, 1));
      end else if (roll >= 90 && roll < 97) begin
        clock_ms = clock_ms + TIME_BITS'($urandom_range(8 * step_max, step_max));
      end else if (roll >= 97) begin
        clock_ms = $urandom;
      end

      // Buttons are mostly held, with single toggles that also model bounce.
      roll = $urandom_range(99);
      if (roll < 12) begin
        btn = $urandom_range(NUM_BUTTONS - 1);
        pin_state[btn] = ~pin_state[btn];
      end else if (roll < 15) begin
        pin_state = NUM_BUTTONS'($urandom);
      end else if (roll < 17) begin
        pin_state = '1;
      end else if (roll < 19) begin
        pin_state = '0;
      end

      // A rare start in the middle reseeds the state.
      if ($urandom_range(99) < 2) begin
        send_item(CMD_START, pin_state, clock_ms);
      end else begin
        send_item(CMD_POLL, pin_state, clock_ms);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(RECV_HEAVY);

    // Directed part with the reset timings (30, 500, 200 ms).
    // A poll before any start gives nothing.
    send_item(CMD_POLL, 5'h00, 32'd100);
    // Up press, debounce, first repeat, a repeat not yet due, then due, release.
    send_item(CMD_START, 5'h1F, 32'd0);
    send_item(CMD_POLL, 5'h1E, 32'd10);
    send_item(CMD_POLL, 5'h1E, 32'd40);
    send_item(CMD_POLL, 5'h1E, 32'd540);
    send_item(CMD_POLL, 5'h1E, 32'd739);
    send_item(CMD_POLL, 5'h1E, 32'd740);
    send_item(CMD_POLL, 5'h1F, 32'd745);
    // All buttons together: the lowest index wins, then Up and Down repeat in turn.
    send_item(CMD_POLL, 5'h00, 32'd800);
    send_item(CMD_POLL, 5'h00, 32'd830);
    send_item(CMD_POLL, 5'h00, 32'd1330);
    send_item(CMD_POLL, 5'h00, 32'd1331);
    // Debounce across the time wrap, with Ok released at the same moment.
    send_item(CMD_START, 5'h0F, 32'hFFFF_FFF0);
    send_item(CMD_POLL, 5'h1E, 32'hFFFF_FFFF);
    send_item(CMD_POLL, 5'h1E, 32'h0000_001D);
    // A Down repeat whose due time lands exactly on zero.
    send_item(CMD_START, 5'h1F, 32'hFFFF_FDEE);
    send_item(CMD_POLL, 5'h1D, 32'hFFFF_FDEE);
    send_item(CMD_POLL, 5'h1D, 32'hFFFF_FE0C);
    send_item(CMD_POLL, 5'h1D, 32'h0000_0000);
    // A start with buttons already down arms no repeat.
    send_item(CMD_START, 5'h00, 32'd5);
    send_item(CMD_POLL, 5'h00, 32'd600);
    send_item(CMD_POLL, 5'h1F, 32'd601);

    // Random phases over several timing settings and all idling patterns.
    run_timing_phase(RECV_HEAVY, 16'd5, 16'd40, 16'd15, 8, 280);
    run_timing_phase(RECV_HEAVY, 16'd0, 16'd0, 16'd0, 4, 280);
    run_timing_phase(SEND_HEAVY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 30000, 280);
    run_timing_phase(SEND_HEAVY, 16'd1, 16'd3, 16'd1, 3, 280);
    run_timing_phase(NO_IDLE, CFG_W'($urandom_range(20)), CFG_W'($urandom_range(100)),
                     CFG_W'($urandom_range(50)), 10, 280);
    run_timing_phase(NO_IDLE, DEBOUNCE_RST, DELAY_RST, INTERVAL_RST, 40, 280);

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d items under %0d timing settings, %0d results with an event,",
             items_sent, settings_used, event_count);
    $display("with heavy result stalls, heavy item gaps and back-to-back traffic.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fbda_pkg.sv
rtl/fbda_core.sv
rtl/five_button_debounce_autorepeat.sv
test/nav_event_checker.sv
test/testbench.sv
